FILE: rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int WORD_W   = 32;

   typedef enum logic [3:0] {
      CMD_APPEND    = 4'd0,
      CMD_PREPEND   = 4'd1,
      CMD_INSERT_AT = 4'd2,
      CMD_READ_AT   = 4'd3,
      CMD_READ_LAST = 4'd4,
      CMD_DEL_FIRST = 4'd5,
      CMD_DEL_LAST  = 4'd6,
      CMD_DEL_AT    = 4'd7,
      CMD_DEL_VALUE = 4'd8,
      CMD_CLEAR     = 4'd9
   } command_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

FILE: rtl/positional_list_engine_unit.sv
// Bounded ordered list of signed words with insert, read and delete by position, delete by value and clear.
//
// The request channel (req_) carries one command with a position and a value.
// The response channel (rsp_) returns exactly one transaction per request: the
// value read (-1 when nothing is read), a status and the entry count after
// the request. Both channels use valid and stall; a transaction moves at a
// rising edge where valid is high and stall is low.
//
// A request is captured in an input register; once it advances, the shift,
// match and read logic over all entries runs in one pass and the response
// is written to the output register while the list is updated. A request
// thus passes the input register and then the output register, and while
// the receiver does not stall one request is taken every cycle. The next
// request sees the list as left by the previous one, since both are updated
// at the same edge.
//
// When the receiver stalls, the response holds and the input register keeps
// its request; the request side is stalled only once the input register is
// full and cannot drain. Reset empties the list and drops any transaction in
// flight; the entry storage itself is not cleared.
module positional_list_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [3:0]                        req_command,
   input  logic [3:0]                        req_position,
   input  logic signed [ple_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ple_pkg::WORD_W-1:0] rsp_read_value,
   output logic [1:0]                        rsp_status,
   output logic [4:0]                        rsp_entry_count
);

   localparam int CAP = ple_pkg::CAPACITY;
   localparam int CW  = ple_pkg::COUNT_W;
   localparam int IW  = ple_pkg::IDX_W;
   localparam int WW  = ple_pkg::WORD_W;

   logic                 in_valid_ff;
   logic [3:0]           in_command_ff;
   logic [3:0]           in_position_ff;
   logic signed [WW-1:0] in_value_ff;

   logic signed [WW-1:0] entries_ff [CAP];
   logic signed [WW-1:0] entries_in [CAP];
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;

   logic                 out_valid_ff;
   logic signed [WW-1:0] out_read_value_ff;
   logic [1:0]           out_status_ff;
   logic [CW-1:0]        out_count_ff;
   logic signed [WW-1:0] read_value_in;
   logic [1:0]           status_in;

   logic                 advance;
   logic                 in_take;

   logic signed [WW-1:0] shift_up   [CAP];
   logic signed [WW-1:0] shift_down [CAP];
   logic [CAP-1:0]       match;
   logic [IW-1:0]        match_idx;
   logic                 found;
   logic                 is_empty;
   logic                 is_full;
   logic                 pos_bad;
   logic [IW-1:0]        pos_idx;
   logic [IW-1:0]        last_idx;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_take   = req_valid && !req_stall;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff >= CW'(CAP));
   assign pos_bad  = ({{(CW > 4 ? CW - 4 : 0){1'b0}}, in_position_ff} >= count_ff);
   assign pos_idx  = IW'(in_position_ff);
   assign last_idx = IW'(count_ff - CW'(1));

   always_comb begin
      shift_up[0] = '0;
      for (int i = 1; i < CAP; i++) begin
         shift_up[i] = entries_ff[i-1];
      end
      for (int i = 0; i < CAP - 1; i++) begin
         shift_down[i] = entries_ff[i+1];
      end
      shift_down[CAP-1] = entries_ff[CAP-1];
   end

   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         match[i] = (CW'(i) < count_ff) && (entries_ff[i] == in_value_ff);
      end
      found = |match;
      match_idx = '0;
      for (int i = CAP - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_idx = IW'(i);
         end
      end
   end

   always_comb begin
      logic          do_ins;
      logic          do_del;
      logic [IW-1:0] ins_idx;
      logic [IW-1:0] del_idx;
      do_ins        = 1'b0;
      do_del        = 1'b0;
      ins_idx       = '0;
      del_idx       = '0;
      read_value_in = '1;
      status_in     = ple_pkg::ST_OK;
      count_in      = count_ff;
      case (in_command_ff)
         ple_pkg::CMD_APPEND: begin
            if (is_full) status_in = ple_pkg::ST_FULL;
            else begin
               do_ins  = 1'b1;
               ins_idx = IW'(count_ff);
            end
         end
         ple_pkg::CMD_PREPEND: begin
            if (is_full) status_in = ple_pkg::ST_FULL;
            else do_ins = 1'b1;
         end
         ple_pkg::CMD_INSERT_AT: begin
            if (is_empty) do_ins = 1'b1;
            else if (is_full) status_in = ple_pkg::ST_FULL;
            else if (pos_bad) status_in = ple_pkg::ST_RANGE;
            else begin
               do_ins  = 1'b1;
               ins_idx = pos_idx;
            end
         end
         ple_pkg::CMD_READ_AT: begin
            if (is_empty) status_in = ple_pkg::ST_EMPTY;
            else if (pos_bad) status_in = ple_pkg::ST_RANGE;
            else read_value_in = entries_ff[pos_idx];
         end
         ple_pkg::CMD_READ_LAST: begin
            if (is_empty) status_in = ple_pkg::ST_EMPTY;
            else read_value_in = entries_ff[last_idx];
         end
         ple_pkg::CMD_DEL_FIRST: begin
            if (is_empty) status_in = ple_pkg::ST_EMPTY;
            else do_del = 1'b1;
         end
         ple_pkg::CMD_DEL_LAST: begin
            if (is_empty) status_in = ple_pkg::ST_EMPTY;
            else count_in = count_ff - CW'(1);
         end
         ple_pkg::CMD_DEL_AT: begin
            if (is_empty) status_in = ple_pkg::ST_EMPTY;
            else if (pos_bad) status_in = ple_pkg::ST_RANGE;
            else begin
               do_del  = 1'b1;
               del_idx = pos_idx;
            end
         end
         ple_pkg::CMD_DEL_VALUE: begin
            if (!found) status_in = ple_pkg::ST_EMPTY;
            else begin
               do_del  = 1'b1;
               del_idx = match_idx;
            end
         end
         ple_pkg::CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase

      if (do_ins) count_in = count_ff + CW'(1);
      if (do_del) count_in = count_ff - CW'(1);

      for (int i = 0; i < CAP; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_ins) begin
            if (IW'(i) == ins_idx) entries_in[i] = in_value_ff;
            else if (IW'(i) > ins_idx) entries_in[i] = shift_up[i];
         end else if (do_del) begin
            if (IW'(i) >= del_idx) entries_in[i] = shift_down[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (in_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_command_ff  <= req_command;
         in_position_ff <= req_position;
         in_value_ff    <= req_value;
      end
      if (advance) begin
         out_read_value_ff <= read_value_in;
         out_status_ff     <= status_in;
         out_count_ff      <= count_in;
         for (int i = 0; i < CAP; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_value  = out_read_value_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_entry_count = 5'(out_count_ff);

endmodule

FILE: rtl/ple_checker.sv
// Port-level checks of the positional list engine and their binding.
module ple_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [ple_pkg::WORD_W-1:0] rsp_read_value,
   input logic [1:0]                        rsp_status,
   input logic [4:0]                        rsp_entry_count
);

   localparam logic [4:0] CAP_COUNT = 5'(ple_pkg::CAPACITY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("Stalled response transaction changed.");

   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_value != -32'sd1) |-> rsp_status == ple_pkg::ST_OK)
      else $error("Read value returned with a failing status.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ple_pkg::ST_FULL |-> rsp_entry_count == CAP_COUNT)
      else $error("Full status with a list that is not full.");

   a_range_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ple_pkg::ST_RANGE |-> rsp_entry_count != 5'd0)
      else $error("Range status on an empty list.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= CAP_COUNT)
      else $error("Entry count exceeds capacity.");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_read_value  (rsp_read_value),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);
